// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the clock core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/utd_pkg.sv -----
// ----------------------------------------------------------------------------
// utd_pkg
// shared types and constants of the uptime and time of day clock
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utd_pkg;

  localparam int HOUR_BITS_DEFAULT = 16;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 88;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SET_DAY = 2'd1,
    CMD_SET_UP  = 2'd2,
    CMD_ELAPSED = 2'd3
  } cmd_t;

  // counter limits
  localparam logic [9:0] MILLI_LAST  = 10'd999;
  localparam logic [5:0] SIXTY_LAST  = 6'd59;
  localparam logic [4:0] DAY_LAST    = 5'd23;

  // range checks on set fields
  localparam logic [15:0] DAY_HOURS   = 16'd24;
  localparam logic [7:0]  SIXTY       = 8'd60;
  localparam logic [15:0] MS_PER_SEC  = 16'd1000;

  // elapsed weights
  localparam logic [31:0] MS_HOUR_W = 32'd3600000;
  localparam logic [31:0] MS_MIN_W  = 32'd60000;
  localparam logic [31:0] MS_SEC_W  = 32'd1000;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] hours;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
    logic [15:0] millis;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] up_hours;
    logic [5:0]  up_minutes;
    logic [5:0]  up_seconds;
    logic [9:0]  up_millis;
    logic [4:0]  day_hours;
    logic [5:0]  day_minutes;
    logic [5:0]  day_seconds;
    logic [31:0] elapsed_ms;
  } res_t;

endpackage

// ----- sv/uptime_and_time_of_day_clock_core.sv -----
// ----------------------------------------------------------------------------
// uptime_and_time_of_day_clock_core
// millisecond uptime clock and time of day clock with a stream interface
// ----------------------------------------------------------------------------
// One command word enters on the s_ side: s_tuser carries the command
// (tick, set time of day, set uptime, elapsed query), s_tdata the hours,
// minutes, seconds and millis fields. Each word yields exactly one result
// word on the m_ side: m_tuser carries the status flag, m_tdata both
// chains after the command and the elapsed milliseconds of a query.
// A word is taken into an input register, then the counter update and the
// elapsed sum run combinationally into the output register, from which the
// result shows on m_tvalid. One word per cycle is sustained while m_tready
// is high; the input register and the output register are the only stages.
// When the receiver holds m_tready low, the result waits in the output
// register while one more word is still taken into the input register;
// s_tready then drops until the result moves on.
// Reset clears both chains to zero and empties both stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uptime_and_time_of_day_clock_core #(
  parameter int HOUR_BITS = utd_pkg::HOUR_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // hours[15:0] minutes[23:16] seconds[31:24] millis[47:32]
  input  logic [utd_pkg::IN_DATA_W-1:0]  s_tdata,
  // command[1:0]
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // up_hours up_minutes up_seconds up_millis day_hours day_minutes
  // day_seconds elapsed_ms, zero pad in bit 87
  output logic [utd_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[0]
  output logic [0:0]                     m_tuser
);

  utd_pkg::item_t s1_item;
  logic           s1_valid;
  logic           advance;
  utd_pkg::res_t  res, m_res;

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.cmd     <= utd_pkg::cmd_t'(s_tuser);
      s1_item.hours   <= s_tdata[15:0];
      s1_item.minutes <= s_tdata[23:16];
      s1_item.seconds <= s_tdata[31:24];
      s1_item.millis  <= s_tdata[47:32];
    end
  end

  utd_clock #(
    .HOUR_BITS(HOUR_BITS)
  ) u_clock (
    .clk (clk),
    .rst (rst),
    .fire(advance),
    .item(s1_item),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_res <= res;
    end
  end

  assign m_tdata = {1'b0, m_res.elapsed_ms, m_res.day_seconds, m_res.day_minutes,
                    m_res.day_hours, m_res.up_millis, m_res.up_seconds,
                    m_res.up_minutes, m_res.up_hours};
  assign m_tuser = m_res.status;

  `ASSERT_ALWAYS(a_status_only_on_set, clk, rst,
    !(s1_valid && (s1_item.cmd == utd_pkg::CMD_TICK ||
      s1_item.cmd == utd_pkg::CMD_ELAPSED)) || !res.status)
  `ASSERT_ALWAYS(a_chain_in_range, clk, rst,
    !m_tvalid || (m_res.up_millis <= utd_pkg::MILLI_LAST &&
      m_res.day_hours <= utd_pkg::DAY_LAST && m_res.up_seconds <= utd_pkg::SIXTY_LAST))
  `ASSERT_NEXT(a_held_word_kept, clk, rst, s1_valid && !advance, s1_valid)
  `ASSERT_NEXT(a_result_follows, clk, rst, advance, m_tvalid)

endmodule

// ----- sv/utd_clock.sv -----
// ----------------------------------------------------------------------------
// utd_clock
// both counter chains with their update, set checks and elapsed query
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utd_clock #(
  parameter int HOUR_BITS = utd_pkg::HOUR_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  utd_pkg::item_t item,
  output utd_pkg::res_t  res
);

  logic [HOUR_BITS-1:0] up_hour, up_hour_next;
  logic [5:0]           up_min, up_min_next;
  logic [5:0]           up_sec, up_sec_next;
  logic [9:0]           up_ms, up_ms_next;
  logic [4:0]           day_hour, day_hour_next;
  logic [5:0]           day_min, day_min_next;
  logic [5:0]           day_sec, day_sec_next;

  logic        bad_day, bad_up;
  logic [31:0] dh, dm, ds, dms;
  logic [31:0] set_hour32;

  assign bad_day = (item.hours >= utd_pkg::DAY_HOURS) || (item.minutes >= utd_pkg::SIXTY) ||
                   (item.seconds >= utd_pkg::SIXTY);
  assign bad_up  = (item.minutes >= utd_pkg::SIXTY) || (item.seconds >= utd_pkg::SIXTY) ||
                   (item.millis >= utd_pkg::MS_PER_SEC);

  assign set_hour32 = 32'(item.hours);
  assign dh  = 32'(up_hour) - 32'(item.hours);
  assign dm  = 32'(up_min) - 32'(item.minutes);
  assign ds  = 32'(up_sec) - 32'(item.seconds);
  assign dms = 32'(up_ms) - 32'(item.millis);

  always_comb begin
    up_hour_next  = up_hour;
    up_min_next   = up_min;
    up_sec_next   = up_sec;
    up_ms_next    = up_ms;
    day_hour_next = day_hour;
    day_min_next  = day_min;
    day_sec_next  = day_sec;
    res.status     = 1'b0;
    res.elapsed_ms = 32'd0;
    case (item.cmd)
      utd_pkg::CMD_TICK: begin
        if (up_ms >= utd_pkg::MILLI_LAST) begin
          up_ms_next = 10'd0;
          if (up_sec >= utd_pkg::SIXTY_LAST) begin
            up_sec_next = 6'd0;
            if (up_min >= utd_pkg::SIXTY_LAST) begin
              up_min_next  = 6'd0;
              up_hour_next = up_hour + {{(HOUR_BITS-1){1'b0}}, 1'b1};
            end else begin
              up_min_next = up_min + 6'd1;
            end
          end else begin
            up_sec_next = up_sec + 6'd1;
          end
          // time of day advances on each second carry
          if (day_sec >= utd_pkg::SIXTY_LAST) begin
            day_sec_next = 6'd0;
            if (day_min >= utd_pkg::SIXTY_LAST) begin
              day_min_next = 6'd0;
              if (day_hour >= utd_pkg::DAY_LAST) begin
                day_hour_next = 5'd0;
              end else begin
                day_hour_next = day_hour + 5'd1;
              end
            end else begin
              day_min_next = day_min + 6'd1;
            end
          end else begin
            day_sec_next = day_sec + 6'd1;
          end
        end else begin
          up_ms_next = up_ms + 10'd1;
        end
      end
      utd_pkg::CMD_SET_DAY: begin
        if (bad_day) begin
          res.status = 1'b1;
        end else begin
          day_hour_next = item.hours[4:0];
          day_min_next  = item.minutes[5:0];
          day_sec_next  = item.seconds[5:0];
        end
      end
      utd_pkg::CMD_SET_UP: begin
        if (bad_up) begin
          res.status = 1'b1;
        end else begin
          up_hour_next = set_hour32[HOUR_BITS-1:0];
          up_min_next  = item.minutes[5:0];
          up_sec_next  = item.seconds[5:0];
          up_ms_next   = item.millis[9:0];
        end
      end
      utd_pkg::CMD_ELAPSED: begin
        res.elapsed_ms = dh * utd_pkg::MS_HOUR_W + dm * utd_pkg::MS_MIN_W +
                         ds * utd_pkg::MS_SEC_W + dms;
      end
      default: begin
        res.status = 1'b0;
      end
    endcase
    res.up_hours    = 16'(up_hour_next);
    res.up_minutes  = up_min_next;
    res.up_seconds  = up_sec_next;
    res.up_millis   = up_ms_next;
    res.day_hours   = day_hour_next;
    res.day_minutes = day_min_next;
    res.day_seconds = day_sec_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_hour  <= '0;
      up_min   <= 6'd0;
      up_sec   <= 6'd0;
      up_ms    <= 10'd0;
      day_hour <= 5'd0;
      day_min  <= 6'd0;
      day_sec  <= 6'd0;
    end else if (fire) begin
      up_hour  <= up_hour_next;
      up_min   <= up_min_next;
      up_sec   <= up_sec_next;
      up_ms    <= up_ms_next;
      day_hour <= day_hour_next;
      day_min  <= day_min_next;
      day_sec  <= day_sec_next;
    end
  end

endmodule
